// ===== src/assert_macros.svh =====
// Assertion macros shared by the hall key note gate RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define HK_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hall key note gate assertion failed");

// Check cons in the cycle after ante.
`define HK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hall key note gate assertion failed");

`endif

// ===== src/hkng_pkg.sv =====
// Types and constants of the hall key note gate.
package hkng_pkg;

  localparam int unsigned KEY_EXT_W   = 9;
  localparam int unsigned VEL_MAX     = 127;
  localparam int unsigned VEL_STEP    = 126;
  localparam int unsigned INTEN_FULL  = 1024;
  localparam int unsigned INTEN_SHIFT = $clog2(INTEN_FULL);
  localparam int unsigned TBL_SHIFT   = 8;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_RESCAN = 1'b1;

  localparam logic [1:0] DIR_NEUTRAL = 2'd0;
  localparam logic [1:0] DIR_PULL    = 2'd1;
  localparam logic [1:0] DIR_PUSH    = 2'd2;

  localparam logic EV_NOTE_ON  = 1'b0;
  localparam logic EV_NOTE_OFF = 1'b1;

  localparam logic [1:0] REG_PRESS_LEVEL    = 2'd0;
  localparam logic [1:0] REG_RELEASE_LEVEL  = 2'd1;
  localparam logic [1:0] REG_TABLE_VELOCITY = 2'd2;

  localparam logic [15:0] PRESS_LEVEL_RST    = 16'd2000;
  localparam logic [15:0] RELEASE_LEVEL_RST  = 16'd2200;
  localparam logic [6:0]  TABLE_VELOCITY_RST = 7'd100;

  typedef struct packed {
    logic        operation;
    logic [4:0]  key_index;
    logic [15:0] reading;
    logic        frame_end;
    logic [6:0]  note;
    logic        note_present;
    logic [1:0]  bellows_dir;
    logic        table_mode;
    logic [10:0] intensity;
    logic [9:0]  sens_scale;
  } item_t;

endpackage

// ===== src/hall_key_note_gate.sv =====
// Top level of the hall key note gate: key samples in, note on/off words out.
//
// Input channel: one word per key sample or per-key rescan, taken when
// in_valid_i is high and in_stall_o is low. Output channel: at most one note
// word per input word, taken when out_valid_o is high and out_stall_i is low.
// Configuration: cfg_we_i writes cfg_wdata_i to the register at cfg_idx_i
// (0 press level, 1 release level, 2 table velocity); write only while idle.
// A result passes the input register at acceptance, then the result register.
// Throughput: one word per cycle while the receiver does not stall, set by
// the update of the per-key minimum and pitch memories, which are read at
// acceptance and written back with forwarding.
// Reset clears pressed and sounding flags, the seeded flag and the output
// valid, and loads the register defaults. The first frame seeds every key
// minimum. While the receiver stalls, the result register holds and the
// input register can still take one more word before in_stall_o rises.
module hall_key_note_gate
  import hkng_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [4:0]  key_index_i,
  input  logic [15:0] reading_i,
  input  logic        frame_end_i,
  input  logic [6:0]  note_i,
  input  logic        note_present_i,
  input  logic [1:0]  bellows_dir_i,
  input  logic        table_mode_i,
  input  logic [10:0] intensity_i,
  input  logic [9:0]  sens_scale_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_kind_o,
  output logic [4:0]  event_key_o,
  output logic [6:0]  event_note_o,
  output logic [6:0]  velocity_o
);

  localparam int unsigned KEY_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [15:0] press_level_q, release_level_q;
  logic [6:0]  table_vel_q;

  logic        s1_valid_q, s1_valid_d;
  item_t       s1_q;
  logic        s1_adv, in_acc;

  logic [15:0] min_mem [NUM_KEYS];
  logic [6:0]  pitch_mem [NUM_KEYS];
  logic [15:0] min_rd_q, fwd_min_q;
  logic [6:0]  pitch_rd_q, fwd_pitch_q;
  logic        fwd_min_hit_q, fwd_pitch_hit_q;

  logic                seeded_q;
  logic [NUM_KEYS-1:0] key_down_q, sounding_q;

  logic        out_valid_q, out_valid_d;
  logic        out_kind_q;
  logic [4:0]  out_key_q;
  logic [6:0]  out_note_q, out_vel_q;

  logic [KEY_EXT_W-1:0] in_key_ext, s1_key_ext;
  logic [KEY_W-1:0]     in_idx, s1_idx;
  logic                 in_range;
  logic [15:0]          min_rd, new_min;
  logic [6:0]           pitch_rd;
  logic                 min_upd, min_we, pitch_we;
  logic                 kd, sv, dir_ok, on_ok;
  logic                 kd_we, kd_val, sv_we, sv_val;
  logic                 emit, emit_kind;
  logic [6:0]           emit_note, emit_vel, on_vel;
  logic [16:0]          tbl_prod;
  logic [8:0]           tbl_vel;
  logic [10:0]          inten_c;
  logic [17:0]          int_prod;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_level_q   <= PRESS_LEVEL_RST;
      release_level_q <= RELEASE_LEVEL_RST;
      table_vel_q     <= TABLE_VELOCITY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PRESS_LEVEL:    press_level_q   <= cfg_wdata_i;
        REG_RELEASE_LEVEL:  release_level_q <= cfg_wdata_i;
        REG_TABLE_VELOCITY: table_vel_q     <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Handshake.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= '{operation: operation_i, key_index: key_index_i, reading: reading_i,
                frame_end: frame_end_i, note: note_i, note_present: note_present_i,
                bellows_dir: bellows_dir_i, table_mode: table_mode_i,
                intensity: intensity_i, sens_scale: sens_scale_i};
    end
  end

  assign in_key_ext = KEY_EXT_W'(key_index_i);
  assign s1_key_ext = KEY_EXT_W'(s1_q.key_index);
  assign in_idx     = in_key_ext[KEY_W-1:0];
  assign s1_idx     = s1_key_ext[KEY_W-1:0];
  assign in_range   = s1_key_ext < KEY_EXT_W'(NUM_KEYS);

  // Per-key memories: read at acceptance, write from the working stage.
  always_ff @(posedge clk_i) begin
    if (min_we) begin
      min_mem[s1_idx] <= new_min;
    end
    if (in_acc) begin
      min_rd_q <= min_mem[in_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pitch_we) begin
      pitch_mem[s1_idx] <= s1_q.note;
    end
    if (in_acc) begin
      pitch_rd_q <= pitch_mem[in_idx];
    end
  end

  // Forward a write that lands on the edge of the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_min_hit_q   <= 1'b0;
      fwd_pitch_hit_q <= 1'b0;
    end else if (in_acc) begin
      fwd_min_hit_q   <= min_we && (s1_q.key_index == key_index_i);
      fwd_pitch_hit_q <= pitch_we && (s1_q.key_index == key_index_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fwd_min_q   <= new_min;
      fwd_pitch_q <= s1_q.note;
    end
  end

  assign min_rd   = fwd_min_hit_q ? fwd_min_q : min_rd_q;
  assign pitch_rd = fwd_pitch_hit_q ? fwd_pitch_q : pitch_rd_q;

  // Velocity.
  always_comb begin
    tbl_prod = 17'(table_vel_q) * 17'(s1_q.sens_scale);
    tbl_vel  = 9'(tbl_prod >> TBL_SHIFT);
    inten_c  = (s1_q.intensity > 11'(INTEN_FULL)) ? 11'(INTEN_FULL) : s1_q.intensity;
    int_prod = 18'(inten_c) * 18'(VEL_STEP);
    if (s1_q.table_mode) begin
      on_vel = (tbl_vel > 9'(VEL_MAX)) ? 7'(VEL_MAX) : tbl_vel[6:0];
    end else begin
      on_vel = 7'(int_prod >> INTEN_SHIFT) + 7'd1;
    end
  end

  // Key update.
  always_comb begin
    kd      = key_down_q[s1_idx];
    sv      = sounding_q[s1_idx];
    dir_ok  = (s1_q.bellows_dir == DIR_PULL) || (s1_q.bellows_dir == DIR_PUSH);
    on_ok   = !sv && dir_ok && s1_q.note_present;
    min_upd = !seeded_q || (s1_q.reading < min_rd);
    new_min = min_upd ? s1_q.reading : min_rd;

    min_we    = 1'b0;
    pitch_we  = 1'b0;
    kd_we     = 1'b0;
    kd_val    = 1'b0;
    sv_we     = 1'b0;
    sv_val    = 1'b0;
    emit      = 1'b0;
    emit_kind = EV_NOTE_ON;
    emit_note = s1_q.note;
    emit_vel  = on_vel;

    if (in_range) begin
      if (s1_q.operation == OP_RESCAN) begin
        if (!dir_ok) begin
          if (sv) begin
            emit      = 1'b1;
            emit_kind = EV_NOTE_OFF;
            sv_we     = 1'b1;
          end
        end else if (kd && on_ok) begin
          emit     = 1'b1;
          sv_we    = 1'b1;
          sv_val   = 1'b1;
          pitch_we = 1'b1;
        end
      end else begin
        min_we = min_upd;
        if (new_min != 16'd0) begin
          if (!kd && (s1_q.reading <= press_level_q)) begin
            kd_we  = 1'b1;
            kd_val = 1'b1;
            if (on_ok) begin
              emit     = 1'b1;
              sv_we    = 1'b1;
              sv_val   = 1'b1;
              pitch_we = 1'b1;
            end
          end else if (kd && (s1_q.reading >= release_level_q)) begin
            kd_we = 1'b1;
            if (sv) begin
              emit      = 1'b1;
              emit_kind = EV_NOTE_OFF;
              sv_we     = 1'b1;
            end
          end
        end
      end
    end

    if (emit_kind == EV_NOTE_OFF) begin
      emit_note = pitch_rd;
      emit_vel  = 7'd0;
    end

    min_we   = min_we && s1_adv;
    pitch_we = pitch_we && s1_adv;
    kd_we    = kd_we && s1_adv;
    sv_we    = sv_we && s1_adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q   <= 1'b0;
      key_down_q <= '0;
      sounding_q <= '0;
    end else begin
      if (s1_adv && (s1_q.operation == OP_SAMPLE) && s1_q.frame_end) begin
        seeded_q <= 1'b1;
      end
      if (kd_we) begin
        key_down_q[s1_idx] <= kd_val;
      end
      if (sv_we) begin
        sounding_q[s1_idx] <= sv_val;
      end
    end
  end

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = emit;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      out_kind_q <= emit_kind;
      out_key_q  <= s1_q.key_index;
      out_note_q <= emit_note;
      out_vel_q  <= emit_vel;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign event_key_o  = out_key_q;
  assign event_note_o = out_note_q;
  assign velocity_o   = out_vel_q;

`include "assert_macros.svh"

  `HK_ASSERT(a_off_no_vel, out_valid_o && (event_kind_o == EV_NOTE_OFF), velocity_o == 7'd0)
  `HK_ASSERT_NXT(a_on_sets_sounding, s1_adv && emit && (emit_kind == EV_NOTE_ON),
                 sounding_q[$past(s1_idx)])
  `HK_ASSERT_NXT(a_fwd_min_hit, in_acc && min_we && (s1_q.key_index == key_index_i),
                 fwd_min_hit_q)
  `HK_ASSERT(a_out_from_adv, $rose(out_valid_q), $past(s1_adv))

endmodule
